FILE: rtl/ray_box_slab_intersect_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the slab intersect block
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_INTERSECT_DEFINES_SVH
`define RAY_BOX_SLAB_INTERSECT_DEFINES_SVH
// implication checked on every rising clock edge, off during reset
`define RBS_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// next-cycle implication
`define RBS_ASSERT_NXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

FILE: rtl/rbs_pkg.sv
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared widths and types for the ray versus box slab intersect block.
// ----------------------------------------------------------------------------
package rbs_pkg;
   localparam int FracBits  = 12;
   localparam int CoordBits = 16;
   localparam int ExtBits   = 15;
   localparam int NumBits   = CoordBits + 2;              // s - o range
   localparam int DividendBits = NumBits + FracBits;      // 30
   localparam int QuoBits   = DividendBits + 1;           // signed quotient
   localparam int DivSteps  = DividendBits;               // one bit per cell
   localparam int DistBits  = 16;

   typedef logic signed [CoordBits-1:0] coord_type;
   typedef logic signed [QuoBits-1:0]   quo_type;

   // one ray in flight through the divider row
   typedef struct packed {
      logic [2:0]              par_miss;   // parallel axis outside slab
      logic [2:0]              zero_dir;
      logic [2:0]              dir_neg;
      logic [2:0][DividendBits-1:0] rem_a;  // magnitude remainders
      logic [2:0][DividendBits-1:0] rem_b;
      logic [2:0][DividendBits-1:0] num_a;  // dividend magnitude, shifted out
      logic [2:0][DividendBits-1:0] num_b;
      logic [2:0][DividendBits-1:0] quo_a;
      logic [2:0][DividendBits-1:0] quo_b;
      logic [2:0]              sign_a;     // quotient negative
      logic [2:0]              sign_b;
      logic [2:0][CoordBits-1:0] dmag;
   } ray_type;

   typedef struct packed {
      logic                 hit;
      logic [DistBits-1:0]  hit_distance;
      logic [1:0]           face_axis;
      logic                 face_negative;
   } rsp_type;
endpackage

FILE: rtl/rbs_if.sv
// ----------------------------------------------------------------------------
// rbs_req_if / rbs_rsp_if
// Valid-ready channels for rays and results.
// ----------------------------------------------------------------------------
interface rbs_req_if;
   logic valid;
   logic ready;
   rbs_pkg::coord_type origin_x, origin_y, origin_z, dir_x, dir_y, dir_z;
   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   input ready);
   modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   output ready);
endinterface

interface rbs_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic [rbs_pkg::DistBits-1:0] hit_distance;
   logic [1:0] face_axis;
   logic face_negative;
   modport source (output valid, hit, hit_distance, face_axis, face_negative,
                   input ready);
   modport sink   (input valid, hit, hit_distance, face_axis, face_negative,
                   output ready);
endinterface

FILE: rtl/rbs_div_cell.sv
// ----------------------------------------------------------------------------
// rbs_div_cell
// One restoring-division step for all six quotients of a ray.
// ----------------------------------------------------------------------------
module rbs_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             valid_in,
   input  rbs_pkg::ray_type ray_in,
   output logic             valid_out,
   output rbs_pkg::ray_type ray_out
);
   localparam int W = rbs_pkg::DividendBits;
   logic             valid_ff;
   rbs_pkg::ray_type ray_ff, ray_in_c;

   function automatic void step(input logic [W-1:0] rem, input logic [W-1:0] num,
                                input logic [W-1:0] quo,
                                input logic [rbs_pkg::CoordBits-1:0] d,
                                output logic [W-1:0] rem_o, output logic [W-1:0] num_o,
                                output logic [W-1:0] quo_o);
      logic [W:0] trial;
      logic [W:0] diff;
      trial = {rem, num[W-1]};
      diff  = trial - {{(W+1-rbs_pkg::CoordBits){1'b0}}, d};
      num_o = {num[W-2:0], 1'b0};
      if (!diff[W]) begin
         rem_o = diff[W-1:0];
         quo_o = {quo[W-2:0], 1'b1};
      end else begin
         rem_o = trial[W-1:0];
         quo_o = {quo[W-2:0], 1'b0};
      end
   endfunction

   always_comb begin
      ray_in_c = ray_in;
      for (int i = 0; i < 3; i++) begin
         step(ray_in.rem_a[i], ray_in.num_a[i], ray_in.quo_a[i], ray_in.dmag[i],
              ray_in_c.rem_a[i], ray_in_c.num_a[i], ray_in_c.quo_a[i]);
         step(ray_in.rem_b[i], ray_in.num_b[i], ray_in.quo_b[i], ray_in.dmag[i],
              ray_in_c.rem_b[i], ray_in_c.num_b[i], ray_in_c.quo_b[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (advance) valid_ff <= valid_in;
      if (advance) ray_ff <= ray_in_c;
   end

   assign valid_out = valid_ff;
   assign ray_out   = ray_ff;
endmodule

FILE: rtl/rbs_resolve.sv
// ----------------------------------------------------------------------------
// rbs_resolve
// Floors the quotients, picks entry and exit, and forms the result.
// ----------------------------------------------------------------------------
module rbs_resolve (
   input  rbs_pkg::ray_type ray,
   output rbs_pkg::rsp_type rsp
);
   localparam int W = rbs_pkg::DividendBits;
   localparam int Q = rbs_pkg::QuoBits;

   function automatic rbs_pkg::quo_type signed_floor(input logic [W-1:0] q,
                                                     input logic [W-1:0] r,
                                                     input logic neg);
      rbs_pkg::quo_type v;
      v = $signed({1'b0, q});
      if (neg) v = -v - ((r != '0) ? Q'(1) : Q'(0));
      return v;
   endfunction

   rbs_pkg::quo_type ta, tb, tn, tf, t_enter, t_exit, t;
   logic found, miss;
   always_comb begin
      t_enter = '0; t_exit = '0; found = 1'b0; miss = |ray.par_miss;
      rsp = '0;
      for (int i = 0; i < 3; i++) begin
         ta = signed_floor(ray.quo_a[i], ray.rem_a[i], ray.sign_a[i]);
         tb = signed_floor(ray.quo_b[i], ray.rem_b[i], ray.sign_b[i]);
         tn = (ta < tb) ? ta : tb;
         tf = (ta < tb) ? tb : ta;
         if (!ray.zero_dir[i]) begin
            if (!found || tn > t_enter) begin
               t_enter = tn;
               rsp.face_axis = 2'(i);
               rsp.face_negative = !ray.dir_neg[i];
            end
            if (!found || tf < t_exit) t_exit = tf;
            found = 1'b1;
         end
      end
      if (!found || t_enter > t_exit || t_exit < Q'(1)) miss = 1'b1;
      t = (t_enter >= Q'(1)) ? t_enter : t_exit;
      if (miss) rsp = '0;
      else begin
         rsp.hit = 1'b1;
         rsp.hit_distance = (t > Q'(65535)) ? 16'hFFFF : t[15:0];
      end
   end
endmodule

FILE: rtl/ray_box_slab_intersect.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Slab test of a ray against the cube [-s,s]^3, signed Q4.12 coordinates.
// ----------------------------------------------------------------------------
// Accepts one ray per cycle while the row is not stalled. Each ray passes a row
// of 30 division cells (one quotient bit per cell for all six slab parameters),
// then a result register. The whole row advances together; it stalls only when
// the response register is full and not being taken.
`include "ray_box_slab_intersect_defines.svh"
module ray_box_slab_intersect (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_we,
   input  logic [14:0]    csr_wdata,
   rbs_req_if.sink        req,
   rbs_rsp_if.source      rsp
);
   localparam int N = rbs_pkg::DivSteps;
   localparam int W = rbs_pkg::DividendBits;

   logic [14:0] half_extent_ff;
   logic        advance;
   logic [N:0]  valid_c;
   rbs_pkg::ray_type ray_c [N+1];
   rbs_pkg::rsp_type res_c, rsp_ff;
   logic        rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) half_extent_ff <= 15'd3277;
      else if (csr_we) half_extent_ff <= csr_wdata;
   end

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance;

   function automatic logic [W-1:0] mag(input logic signed [rbs_pkg::NumBits-1:0] v);
      logic [rbs_pkg::NumBits-1:0] m;
      m = v[rbs_pkg::NumBits-1] ? rbs_pkg::NumBits'(-v) : v;
      return {m, {rbs_pkg::FracBits{1'b0}}};
   endfunction

   always_comb begin
      logic signed [rbs_pkg::NumBits-1:0] s, o, na, nb;
      logic signed [rbs_pkg::CoordBits-1:0] d;
      logic signed [rbs_pkg::CoordBits:0] dw;
      rbs_pkg::coord_type org [3];
      rbs_pkg::coord_type dir [3];
      org[0] = req.origin_x; org[1] = req.origin_y; org[2] = req.origin_z;
      dir[0] = req.dir_x;    dir[1] = req.dir_y;    dir[2] = req.dir_z;
      s = $signed({3'b000, half_extent_ff});
      ray_c[0] = '0;
      for (int i = 0; i < 3; i++) begin
         o  = rbs_pkg::NumBits'(org[i]);
         d  = dir[i];
         dw = (rbs_pkg::CoordBits+1)'(d);
         na = -s - o;
         nb = s - o;
         ray_c[0].zero_dir[i] = (d == '0);
         ray_c[0].par_miss[i] = (d == '0) && (o < -s || o > s);
         ray_c[0].dir_neg[i]  = d[rbs_pkg::CoordBits-1];
         ray_c[0].dmag[i]     = d[rbs_pkg::CoordBits-1] ?
                                rbs_pkg::CoordBits'(-dw) : d;
         ray_c[0].num_a[i]    = mag(na);
         ray_c[0].num_b[i]    = mag(nb);
         ray_c[0].sign_a[i]   = (na != '0) && (na[rbs_pkg::NumBits-1] ^ d[rbs_pkg::CoordBits-1]);
         ray_c[0].sign_b[i]   = (nb != '0) && (nb[rbs_pkg::NumBits-1] ^ d[rbs_pkg::CoordBits-1]);
      end
   end
   assign valid_c[0] = req.valid;

   for (genvar k = 0; k < N; k++) begin : g_cell
      rbs_div_cell u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .valid_in(valid_c[k]), .ray_in(ray_c[k]),
         .valid_out(valid_c[k+1]), .ray_out(ray_c[k+1])
      );
   end

   rbs_resolve u_resolve (.ray(ray_c[N]), .rsp(res_c));

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= valid_c[N];
      if (advance) rsp_ff <= res_c;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.hit           = rsp_ff.hit;
   assign rsp.hit_distance  = rsp_ff.hit_distance;
   assign rsp.face_axis     = rsp_ff.face_axis;
   assign rsp.face_negative = rsp_ff.face_negative;

   `RBS_ASSERT_NXT(a_hold, clock, reset, rsp_valid_ff && !rsp.ready, rsp_valid_ff && $stable(rsp_ff))
   `RBS_ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid_ff && !rsp_ff.hit, rsp_ff == '0)
   `RBS_ASSERT_IMP(a_axis, clock, reset, rsp_valid_ff, rsp_ff.face_axis != 2'd3)
endmodule

FILE: tb/rbs_checker.sv
// ----------------------------------------------------------------------------
// rbs_checker
// Watches the ray and result channels of the slab intersect block, predicts
// each result from the accepted ray and the current half extent, and compares
// the results in order.
// ----------------------------------------------------------------------------
module rbs_checker (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [14:0]   csr_wdata,
   rbs_req_if            req,
   rbs_rsp_if            rsp,
   output int            fail_count,
   output int            pending
);
   logic [14:0]      half_size;
   rbs_pkg::rsp_type hit_queue[$];

   // floor(num * 2^FracBits / den), den nonzero
   function automatic longint slab_t(longint num, longint den);
      longint n;
      longint q;
      longint r;
      n = num * (64'sd1 <<< rbs_pkg::FracBits);
      q = n / den;
      r = n % den;
      if (r != 0 && ((r < 0) != (den < 0))) q = q - 1;
      return q;
   endfunction

   function automatic rbs_pkg::rsp_type predict_hit(
         rbs_pkg::coord_type ox, rbs_pkg::coord_type oy, rbs_pkg::coord_type oz,
         rbs_pkg::coord_type dx, rbs_pkg::coord_type dy, rbs_pkg::coord_type dz,
         logic [14:0] s);
      longint  o[3];
      longint  d[3];
      longint  sl;
      longint  t_in;
      longint  t_out;
      longint  ta;
      longint  tb;
      longint  tn;
      longint  tf;
      longint  t;
      int      axis;
      logic    neg;
      logic    miss;
      rbs_pkg::rsp_type res;
      o[0] = ox; o[1] = oy; o[2] = oz;
      d[0] = dx; d[1] = dy; d[2] = dz;
      sl = s;
      t_in = 64'sh8000_0000_0000_0000;
      t_out = 64'sh7FFF_FFFF_FFFF_FFFF;
      axis = -1;
      neg = 1'b0;
      miss = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (d[i] == 0) begin
            if (o[i] < -sl || o[i] > sl) miss = 1'b1;
         end else begin
            ta = slab_t(-sl - o[i], d[i]);
            tb = slab_t(sl - o[i], d[i]);
            tn = (ta < tb) ? ta : tb;
            tf = (ta < tb) ? tb : ta;
            if (tn > t_in) begin
               t_in = tn;
               axis = i;
               neg = d[i] > 0;
            end
            if (tf < t_out) t_out = tf;
         end
      end
      if (axis < 0 || t_in > t_out || t_out < 1) miss = 1'b1;
      res = '0;
      if (!miss) begin
         t = (t_in >= 1) ? t_in : t_out;
         if (t > 65535) t = 65535;
         res.hit = 1'b1;
         res.hit_distance = t[15:0];
         res.face_axis = axis[1:0];
         res.face_negative = neg;
      end
      return res;
   endfunction

   assign pending = hit_queue.size();

   always @(posedge clock) begin
      rbs_pkg::rsp_type want;
      rbs_pkg::rsp_type got;
      if (reset) begin
         half_size <= 15'd3277;
         hit_queue.delete();
         fail_count <= 0;
      end else begin
         if (req.valid && req.ready)
            hit_queue.push_back(predict_hit(req.origin_x, req.origin_y, req.origin_z,
                                            req.dir_x, req.dir_y, req.dir_z, half_size));
         if (csr_we) half_size <= csr_wdata;
         if (rsp.valid && rsp.ready) begin
            got.hit = rsp.hit;
            got.hit_distance = rsp.hit_distance;
            got.face_axis = rsp.face_axis;
            got.face_negative = rsp.face_negative;
            if (hit_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected result beat: %p", got);
               fail_count <= fail_count + 1;
            end else begin
               want = hit_queue.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("result mismatch: expected %p, actual %p", want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

   initial fail_count = 0;
endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives rays and half extent settings into the slab intersect block, with
// random gaps and stalls on both channels; the checker judges the results.
// ----------------------------------------------------------------------------
module tb_top;
   localparam int CycleLimit = 400000;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [14:0] csr_wdata;
   logic [14:0] half_now;
   int          fail_count;
   int          pending;
   int          cycles;
   bit          no_idle;
   bit          hold_req;

   rbs_req_if req ();
   rbs_rsp_if rsp ();

   ray_box_slab_intersect uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req.sink),
      .rsp       (rsp.source)
   );

   rbs_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req        (req),
      .rsp        (rsp),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("ray_box_slab_intersect regression: fail");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && hold_left == 0) begin
            hold_left = 300;
            hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready = 1'b0;
         end else begin
            rsp.ready = no_idle || ($urandom_range(99) >= 37);
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the beat
   task automatic send_ray(rbs_pkg::coord_type ox, rbs_pkg::coord_type oy,
                           rbs_pkg::coord_type oz, rbs_pkg::coord_type dx,
                           rbs_pkg::coord_type dy, rbs_pkg::coord_type dz);
      while (!no_idle && $urandom_range(99) < 37) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.valid = 1'b1;
      req.origin_x = ox; req.origin_y = oy; req.origin_z = oz;
      req.dir_x = dx; req.dir_y = dy; req.dir_z = dz;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
      req.valid = 1'b0;
   endtask

   task automatic set_half(logic [14:0] v);
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = v;
      half_now = v;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic rbs_pkg::coord_type clamp16(int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return rbs_pkg::coord_type'(v);
   endfunction

   function automatic rbs_pkg::coord_type rand_coord(int span);
      if ($urandom_range(9) == 0) return rbs_pkg::coord_type'($urandom());
      return clamp16($urandom_range(2 * span) - span);
   endfunction

   // mostly rays aimed at a point of the box, the rest free noise
   task automatic send_random();
      int s;
      int tgt[3];
      int org[3];
      int dd[3];
      int div;
      s = half_now;
      div = $urandom_range(1, 6);
      for (int i = 0; i < 3; i++) begin
         tgt[i] = $urandom_range(2 * s) - s;
         org[i] = rand_coord(s * 3 + 100);
         dd[i] = (tgt[i] - org[i]) / div;
         if ($urandom_range(9) == 0) dd[i] = 0;
         if ($urandom_range(9) == 0) dd[i] = -dd[i];
      end
      if ($urandom_range(3) == 0)
         send_ray(rand_coord(40000), rand_coord(40000), rand_coord(40000),
                  rand_coord(40000), rand_coord(40000), rand_coord(40000));
      else
         send_ray(clamp16(org[0]), clamp16(org[1]), clamp16(org[2]),
                  clamp16(dd[0]), clamp16(dd[1]), clamp16(dd[2]));
   endtask

   initial begin
      logic [14:0] sizes[6];
      cycles = 0;
      no_idle = 1'b0;
      hold_req = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      half_now = 15'd3277;
      req.valid = 1'b0;
      req.origin_x = '0; req.origin_y = '0; req.origin_z = '0;
      req.dir_x = '0; req.dir_y = '0; req.dir_z = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rays at the reset half extent of 3277
      send_ray(0, 0, 0, 0, 0, 0);                   // no direction at all
      send_ray(3277, 0, 0, 0, 0, 4096);             // parallel on the slab bound
      send_ray(-3277, 0, -8000, 0, 0, 4096);        // parallel on the low bound
      send_ray(3278, 0, 0, 0, 0, 4096);             // parallel just outside
      send_ray(-8192, 0, 0, 4096, 0, 0);            // straight hit on minus x
      send_ray(0, 8192, 0, 0, -4096, 0);            // hit on plus y
      send_ray(0, 0, -8192, 0, 0, 4096);            // hit on minus z
      send_ray(0, 0, 0, 4096, 1000, -2000);         // origin inside
      send_ray(8192, 0, 0, 4096, 0, 0);             // box behind
      send_ray(-8192, -8192, -8192, 4096, 4096, 4096); // tie on all axes
      send_ray(-8192, 8192, 0, 4096, 4096, 0);      // empty interval
      send_ray(-32768, 0, 0, 1, 0, 0);              // far distance, saturates
      send_ray(32767, 32767, 32767, -32768, -32768, -32768);
      send_ray(-32768, -32768, -32768, 32767, 32767, 32767);
      send_ray(-32768, 0, 0, -1, 0, 0);
      send_ray(16'sh7FFF, 16'sh8000, 16'sh5555, 16'shAAAA, 16'sh0001, 16'shFFFF);

      sizes = '{15'd1, 15'd32767, 15'd3277, 15'd200, 15'd12000, 15'd0};
      for (int p = 0; p < 6; p++) begin
         set_half(p == 5 ? 15'($urandom_range(1, 32767)) : sizes[p]);
         send_ray(0, 0, 0, 0, 0, 0);
         send_ray(clamp16(half_now), 0, 0, 0, 0, 1);
         send_ray(-32768, 0, 0, 32767, 0, 0);
         no_idle = (p == 2);
         if (p == 3) hold_req = 1'b1;    // long receiver hold-off; keep offering
         for (int n = 0; n < 220; n++) send_random();
         no_idle = 1'b0;
      end

      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0)
         $display("ray_box_slab_intersect regression: pass");
      else
         $display("ray_box_slab_intersect regression: fail");
      $finish;
   end
endmodule
